// ----- hw/rtl/ngm_pkg.sv -----
`timescale 1ns / 1ps

package ngm_pkg;

  localparam int NUM_GATES = 8;
  localparam int GATE_W    = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

  localparam logic [31:0] LIMIT_RESET = 32'd655294464;  // 9999.0 in q16.16
  localparam logic [31:0] DIST_SAT    = 32'hFFFF_FFFF;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // multiplier operand and product widths
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] cos;
    logic signed [15:0] sin;
  } gate_entry_t;

  typedef struct packed {
    logic              en;
    logic [GATE_W-1:0] idx;
    gate_entry_t       entry;
  } gate_wr_t;

  // round q.22 rotation result to q8.8, half up, floor shift
  function automatic logic signed [19:0] rot_round(input logic signed [32:0] r);
    logic signed [33:0] t;
    t = 34'(r) + 34'sd8192;
    return t[33:14];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] res;
    if (v > 21'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/ngm_if.sv -----
`timescale 1ns / 1ps

interface ngm_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [2:0]         gate_index;
  logic signed [15:0] gate_x;
  logic signed [15:0] gate_y;
  logic signed [15:0] gate_cos;
  logic signed [15:0] gate_sin;
  logic signed [15:0] meas_dx;
  logic signed [15:0] meas_dy;
  logic signed [15:0] est_x;
  logic signed [15:0] est_y;
  logic signed [15:0] corr_x;
  logic signed [15:0] corr_y;

  modport source (
    output valid, op, gate_index, gate_x, gate_y, gate_cos, gate_sin,
           meas_dx, meas_dy, est_x, est_y, corr_x, corr_y,
    input  ready
  );
  modport sink (
    input  valid, op, gate_index, gate_x, gate_y, gate_cos, gate_sin,
           meas_dx, meas_dy, est_x, est_y, corr_x, corr_y,
    output ready
  );
endinterface

interface ngm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] match_x;
  logic signed [15:0] match_y;
  logic               match_found;
  logic [2:0]         match_gate;
  logic [31:0]        match_distance;

  modport source (
    output valid, match_x, match_y, match_found, match_gate, match_distance,
    input  ready
  );
  modport sink (
    input  valid, match_x, match_y, match_found, match_gate, match_distance,
    output ready
  );
endinterface

interface ngm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/ngm_mul.sv -----
`timescale 1ns / 1ps

module ngm_mul (
  input  logic                               clk_i,
  input  logic signed [ngm_pkg::MUL_W-1:0]   a_i,
  input  logic signed [ngm_pkg::MUL_W-1:0]   b_i,
  output logic signed [ngm_pkg::PROD_W-1:0]  prod_o
);
  import ngm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // registered signed product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/ngm_gate_table.sv -----
`timescale 1ns / 1ps

module ngm_gate_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ngm_pkg::gate_wr_t            wr_i,
  input  logic [ngm_pkg::GATE_W-1:0]   rd_idx_i,
  output ngm_pkg::gate_entry_t         rd_entry_o
);
  import ngm_pkg::*;

  gate_entry_t entry_q [NUM_GATES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GATES; i++) begin
        entry_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      entry_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign rd_entry_o = entry_q[rd_idx_i];

endmodule

// ----- hw/rtl/nearest_gate_match.sv -----
`timescale 1ns / 1ps

// nearest_gate_match: nearest-neighbor association of a vision gate detection
// against a table of known gates.
//
// channels: in_i carries one word per request (op 0 loads a table entry,
// op 1 runs a query), out_o returns exactly one result word per request,
// cfg_i writes the distance limit (always ready, write only while idle).
//
// sequencing: a load goes from accept straight to the done state. a query walks
// every table entry through one shared 18x18 multiplier in states M0 to M8 per
// entry (four rotation products, two squares, plus add / saturate slots). one
// request is in flight at a time; in_i.ready is high only while the sequencer idles.
//
// the result sits in an output register, so a new request is accepted while
// a finished result still waits; if out_o stalls, the following request
// finishes its work and holds in its done state until the register frees.
//
// reset: table entries and the last match clear to zero, the limit returns
// to 9999.0 (q16.16), no result is pending.
module nearest_gate_match (
  input  logic clk_i,
  input  logic rst_ni,
  ngm_in_if.sink    in_i,
  ngm_out_if.source out_o,
  ngm_cfg_if.sink   cfg_i
);
  import ngm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_M0   = 11'b000_0000_0010,
    S_M1   = 11'b000_0000_0100,
    S_M2   = 11'b000_0000_1000,
    S_M3   = 11'b000_0001_0000,
    S_M4   = 11'b000_0010_0000,
    S_M5   = 11'b000_0100_0000,
    S_M6   = 11'b000_1000_0000,
    S_M7   = 11'b001_0000_0000,
    S_M8   = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [31:0] limit_q;

  // query operands
  logic signed [15:0] dx_q, dy_q;
  logic signed [16:0] tx_q, ty_q;

  // per-gate datapath
  logic [GATE_W-1:0]        gate_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [32:0]       rot_q;
  logic signed [15:0]       cx_q, cy_q;
  logic signed [17:0]       err_q;

  // running best
  logic [31:0]        best_q;
  logic signed [15:0] bx_q, by_q;
  logic [GATE_W-1:0]  bgate_q;
  logic               found_q;
  logic signed [15:0] last_x_q, last_y_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic               out_found_q;
  logic [2:0]         out_gate_q;
  logic [31:0]        out_dist_q;

  logic               in_fire, out_free, last_gate;
  gate_wr_t           tbl_wr;
  gate_entry_t        ent;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [34:0]        dist_sum;
  logic [31:0]        cand_dist;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign last_gate   = (gate_q == GATE_W'(NUM_GATES - 1));

  // table load goes straight in at accept
  always_comb begin
    tbl_wr.en        = in_fire && (in_i.op == OP_LOAD)
                       && (32'(in_i.gate_index) < NUM_GATES);
    tbl_wr.idx       = GATE_W'(in_i.gate_index);
    tbl_wr.entry.x   = in_i.gate_x;
    tbl_wr.entry.y   = in_i.gate_y;
    tbl_wr.entry.cos = in_i.gate_cos;
    tbl_wr.entry.sin = in_i.gate_sin;
  end

  ngm_gate_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .rd_idx_i   (gate_q),
    .rd_entry_o (ent)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_M0: begin
        mul_a = MUL_W'(ent.cos);
        mul_b = MUL_W'(dx_q);
      end
      S_M1: begin
        mul_a = MUL_W'(ent.sin);
        mul_b = MUL_W'(dy_q);
      end
      S_M2: begin
        mul_a = MUL_W'(ent.sin);
        mul_b = MUL_W'(dx_q);
      end
      S_M3: begin
        mul_a = MUL_W'(ent.cos);
        mul_b = MUL_W'(dy_q);
      end
      S_M5, S_M7: begin
        mul_a = err_q;
        mul_b = err_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ngm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ex^2 + ey^2, both below 2^34, saturate at 32 bits
  assign dist_sum  = {1'b0, acc_q[33:0]} + {1'b0, prod[33:0]};
  assign cand_dist = (dist_sum[34:32] != 3'd0) ? DIST_SAT : dist_sum[31:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.op == OP_QUERY) ? S_M0 : S_DONE;
        end
      end
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_M4;
      S_M4:   state_d = S_M5;
      S_M5:   state_d = S_M6;
      S_M6:   state_d = S_M7;
      S_M7:   state_d = S_M8;
      S_M8:   state_d = last_gate ? S_DONE : S_M0;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      limit_q <= cfg_i.data;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dx_q <= in_i.meas_dx;
        dy_q <= in_i.meas_dy;
        tx_q <= 17'(in_i.est_x) + 17'(in_i.corr_x);
        ty_q <= 17'(in_i.est_y) + 17'(in_i.corr_y);
      end
      S_M1: acc_q <= prod;
      S_M2: rot_q <= $signed(acc_q[32:0]) - $signed(prod[32:0]);
      S_M3: begin
        acc_q <= prod;
        cx_q  <= sat16(21'(ent.x) + 21'(rot_round(rot_q)));
      end
      S_M4: begin
        rot_q <= $signed(acc_q[32:0]) + $signed(prod[32:0]);
        err_q <= 18'(cx_q) - 18'(tx_q);
      end
      S_M5: cy_q <= sat16(21'(ent.y) + 21'(rot_round(rot_q)));
      S_M6: begin
        acc_q <= prod;
        err_q <= 18'(cy_q) - 18'(ty_q);
      end
      default: ;
    endcase
  end

  // gate walk and running best
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q   <= '0;
      found_q  <= 1'b0;
      best_q   <= '0;
      bx_q     <= '0;
      by_q     <= '0;
      bgate_q  <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            gate_q  <= '0;
            found_q <= 1'b0;
            best_q  <= limit_q;
            bgate_q <= '0;
          end
        end
        S_M8: begin
          // strict compare keeps the lowest index on a tie
          if (cand_dist < best_q) begin
            best_q  <= cand_dist;
            bx_q    <= cx_q;
            by_q    <= cy_q;
            bgate_q <= gate_q;
            found_q <= 1'b1;
          end
          if (!last_gate) begin
            gate_q <= gate_q + GATE_W'(1);
          end
        end
        S_DONE: begin
          if (out_free && found_q) begin
            last_x_q <= bx_q;
            last_y_q <= by_q;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_x_q     <= found_q ? bx_q : last_x_q;
      out_y_q     <= found_q ? by_q : last_y_q;
      out_found_q <= found_q;
      out_gate_q  <= found_q ? 3'(bgate_q) : 3'd0;
      out_dist_q  <= found_q ? best_q : 32'd0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.match_x        = out_x_q;
  assign out_o.match_y        = out_y_q;
  assign out_o.match_found    = out_found_q;
  assign out_o.match_gate     = out_gate_q;
  assign out_o.match_distance = out_dist_q;

  // accepted request takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("request accepted but sequencer still idle");

  // a miss or a load reports zero gate and distance
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_gate_q == 3'd0 && out_dist_q == 32'd0))
    else $error("miss result carries gate or distance");

  // finished work waits while the output register is occupied
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");

  // a found match always beats the limit it started from
  a_found_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> (best_q != DIST_SAT))
    else $error("match recorded at saturated distance");

endmodule
